// ===== sv/automaton_constrained_edit_dp_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the constrained edit-distance core
// Implication checks, present cycle and next cycle, removed under SYNTH.
// ---------------------------------------------------------------------------
`ifndef AUTOMATON_CONSTRAINED_EDIT_DP_CORE_MACROS_SVH
`define AUTOMATON_CONSTRAINED_EDIT_DP_CORE_MACROS_SVH
`ifndef SYNTH
`define ACED_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aced check failed");
`define ACED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("aced check failed");
`else
`define ACED_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ACED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/aced_pkg.sv =====
// ---------------------------------------------------------------------------
// Constrained edit-distance package
// Cost codes, field widths and transaction kinds.
// ---------------------------------------------------------------------------
package aced_pkg;
	localparam int CostW     = 11;
	localparam int StateFldW = 10;
	localparam int SymW      = 2;
	localparam logic [CostW-1:0] COST_INF = 11'd2047;

	typedef logic [CostW-1:0] cost_t;

	typedef enum logic [1:0] {
		MODE_LOAD_TRANS = 2'd0,
		MODE_LOAD_FLAG  = 2'd1,
		MODE_BASE       = 2'd2,
		MODE_FINISH     = 2'd3
	} mode_t;
endpackage

// ===== sv/automaton_constrained_edit_dp_core.sv =====
// ---------------------------------------------------------------------------
// Automaton-constrained edit distance core
// Least base substitutions that keep a DNA string clear of forbidden patterns.
// ---------------------------------------------------------------------------
// The host loads the pattern automaton (one next-state per state and symbol,
// one forbidden flag per state), then sends one base transaction per target
// base and a finish transaction that returns the least cost, or flags that no
// valid string exists. A load completes as it is accepted. A base transaction
// first sweeps the spare cost bank to infinity, then visits each state in
// use: it fetches the state's cost and, if reachable, for each symbol fetches
// the transition, fetches the flag and target cost, and writes back. A finish
// scans the current bank, posts the result and then rewrites the bank to
// state 0 = 0, others infinite. After reset the same rewrite runs once,
// during which no transaction is accepted. A waiting result does not block
// loads or bases.
module automaton_constrained_edit_dp_core #(
	parameter int MAX_STATES = 1024,
	parameter int ALPHABET   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [9:0] state_index, [11:10] symbol, [21:12] next_state, [22] forbidden
	input  logic [23:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [10:0] min_cost, [11] impossible
	output logic [15:0] m_tdata
);
	import aced_pkg::*;

	localparam int SW  = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
	localparam int JW  = SW + 1;
	localparam int TAW = $clog2(MAX_STATES * ALPHABET);
	localparam int UW  = $clog2(MAX_STATES + 1);
	localparam logic [JW-1:0] J_LAST = JW'(MAX_STATES - 1);
	localparam logic [JW-1:0] J_END  = JW'(MAX_STATES);
	localparam logic [1:0]    K_LAST = 2'(ALPHABET - 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLRN, ST_RCUR, ST_RLAT, ST_RTR, ST_RNX, ST_UPD,
		ST_SCAN, ST_OUT, ST_CLRC
	} state_t;

	// input fields
	logic [StateFldW-1:0] in_si, in_ns;
	logic [SymW-1:0]      in_sym;
	logic                 in_fb;
	mode_t                in_mode;
	logic                 acc;

	assign in_si   = s_tdata[9:0];
	assign in_sym  = s_tdata[11:10];
	assign in_ns   = s_tdata[21:12];
	assign in_fb   = s_tdata[22];
	assign in_mode = mode_t'(s_tuser);

	// control registers
	state_t          state_q;
	logic [JW-1:0]   j_q;
	logic [1:0]      k_q;
	logic [SymW-1:0] base_q;
	logic            bank_q;
	logic [UW-1:0]   in_use_q;
	cost_t           c_q;
	cost_t           best_q;
	logic [StateFldW-1:0] t_q;
	logic            tok_q;
	logic            rdv_q;
	logic            m_tvalid_q;
	logic [15:0]     m_tdata_q;

	// memories
	logic [StateFldW-1:0] tr_mem [MAX_STATES*ALPHABET];
	logic                 fb_mem [MAX_STATES];
	cost_t                cost_mem [2**(SW+1)];
	logic [StateFldW-1:0] tr_rd_q;
	logic                 fb_rd_q;
	cost_t                cost_rd_q;

	logic           tr_we, fb_we, cost_we;
	logic [TAW-1:0] tr_waddr, tr_raddr;
	logic [SW-1:0]  fb_waddr, fb_raddr;
	logic [SW:0]    cost_waddr, cost_raddr;
	cost_t          cost_wdata;

	logic [SW-1:0]  j_idx, t_idx;
	logic           si_ok, load_ok;
	logic [UW-1:0]  raise_si, raise_ns, in_use_d;
	logic [CostW:0] nc_w;
	cost_t          nc;
	logic           upd_we;
	logic           post;

	assign acc     = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign j_idx   = j_q[SW-1:0];
	assign t_idx   = SW'(tr_rd_q);
	assign si_ok   = 32'(in_si) < MAX_STATES;
	assign load_ok = si_ok && (32'(in_sym) < ALPHABET);
	// result register free or draining this cycle
	assign post    = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// raise the count of states in use to cover a loaded index
	assign raise_si = (32'(in_si) + 1 > MAX_STATES) ? UW'(MAX_STATES) : UW'(32'(in_si) + 1);
	assign raise_ns = (32'(in_ns) + 1 > MAX_STATES) ? UW'(MAX_STATES) : UW'(32'(in_ns) + 1);

	always_comb begin
		in_use_d = in_use_q;
		if (acc && in_mode == MODE_LOAD_TRANS && load_ok) begin
			if (raise_si > in_use_d) in_use_d = raise_si;
			if (raise_ns > in_use_d) in_use_d = raise_ns;
		end else if (acc && in_mode == MODE_LOAD_FLAG && si_ok) begin
			if (raise_si > in_use_d) in_use_d = raise_si;
		end
	end

	// relaxed cost of the move under test; the source is never infinite
	assign nc_w = {1'b0, c_q} + ((32'(k_q) != 32'(base_q)) ? 12'd1 : 12'd0);
	assign nc   = (nc_w >= {1'b0, COST_INF}) ? COST_INF : nc_w[CostW-1:0];
	assign upd_we = tok_q && !fb_rd_q && (nc < cost_rd_q);

	// table write ports
	assign tr_we    = acc && in_mode == MODE_LOAD_TRANS && load_ok;
	assign tr_waddr = TAW'(32'(SW'(in_si)) * ALPHABET + 32'(in_sym));
	assign fb_we    = acc && in_mode == MODE_LOAD_FLAG && si_ok;
	assign fb_waddr = SW'(in_si);
	assign tr_raddr = TAW'(32'(j_idx) * ALPHABET + 32'(k_q));
	assign fb_raddr = t_idx;

	// cost memory ports: current bank is bank_q, spare bank is its inverse
	always_comb begin
		cost_we    = 1'b0;
		cost_waddr = {~bank_q, j_idx};
		cost_wdata = COST_INF;
		cost_raddr = {bank_q, j_idx};
		unique case (state_q)
			ST_CLRN: cost_we = 1'b1;
			ST_CLRC: begin
				cost_we    = 1'b1;
				cost_waddr = {bank_q, j_idx};
				cost_wdata = (j_q == '0) ? '0 : COST_INF;
			end
			ST_RNX: cost_raddr = {~bank_q, t_idx};
			ST_UPD: begin
				cost_we    = upd_we;
				cost_waddr = {~bank_q, SW'(t_q)};
				cost_wdata = nc;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tr_we) tr_mem[tr_waddr] <= in_ns;
		tr_rd_q <= tr_mem[tr_raddr];
	end

	always_ff @(posedge clk) begin
		if (fb_we) fb_mem[fb_waddr] <= in_fb;
		fb_rd_q <= fb_mem[fb_raddr];
	end

	always_ff @(posedge clk) begin
		if (cost_we) cost_mem[cost_waddr] <= cost_wdata;
		cost_rd_q <= cost_mem[cost_raddr];
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLRC;
			j_q        <= '0;
			k_q        <= '0;
			base_q     <= '0;
			bank_q     <= 1'b0;
			in_use_q   <= '0;
			rdv_q      <= 1'b0;
			tok_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			c_q        <= '0;
			best_q     <= COST_INF;
			t_q        <= '0;
		end else begin
			in_use_q <= in_use_d;
			if (post) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					j_q <= '0;
					if (acc && in_mode == MODE_BASE) begin
						base_q  <= in_sym;
						state_q <= ST_CLRN;
					end else if (acc && in_mode == MODE_FINISH) begin
						best_q  <= COST_INF;
						rdv_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_CLRN: begin
					// sweep the spare bank to infinity
					if (j_q == J_LAST) begin
						j_q     <= '0;
						state_q <= ST_RCUR;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_RCUR: begin
					// all states in use relaxed: swap banks
					if (32'(j_q) >= 32'(in_use_q)) begin
						bank_q  <= ~bank_q;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RLAT;
					end
				end
				ST_RLAT: begin
					c_q <= cost_rd_q;
					k_q <= '0;
					if (cost_rd_q >= COST_INF) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_RCUR;
					end else begin
						state_q <= ST_RTR;
					end
				end
				ST_RTR: state_q <= ST_RNX;
				ST_RNX: begin
					t_q     <= tr_rd_q;
					tok_q   <= 32'(tr_rd_q) < MAX_STATES;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (k_q == K_LAST) begin
						j_q     <= j_q + 1'b1;
						state_q <= ST_RCUR;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_RTR;
					end
				end
				ST_SCAN: begin
					// stream the current bank through the minimum
					if (rdv_q && cost_rd_q < best_q) best_q <= cost_rd_q;
					rdv_q <= (j_q != J_END);
					if (j_q == J_END) begin
						state_q <= ST_OUT;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (post) begin
						m_tdata_q  <= {4'd0, best_q >= COST_INF, best_q};
						j_q        <= '0;
						state_q    <= ST_CLRC;
					end
				end
				ST_CLRC: begin
					// rewrite the current bank: state 0 zero, others infinite
					if (j_q == J_LAST) begin
						j_q     <= '0;
						state_q <= ST_IDLE;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`include "automaton_constrained_edit_dp_core_macros.svh"

	// an impossible result always carries the infinity code
	`ACED_ASSERT_NOW(a_imp_inf, clk, arst_n, m_tvalid && m_tdata[11], m_tdata[10:0] == COST_INF)
	// the count of states in use never passes the memory depth
	`ACED_ASSERT_NOW(a_in_use, clk, arst_n, 1'b1, 32'(in_use_q) <= MAX_STATES)
	// relaxation writes only the spare bank
	`ACED_ASSERT_NOW(a_bank, clk, arst_n, state_q == ST_UPD && cost_we, cost_waddr[SW] != bank_q)
	// once the result register is free or draining, a finish posts its result
	`ACED_ASSERT_NEXT(a_post, clk, arst_n, state_q == ST_OUT && (!m_tvalid || m_tready), m_tvalid)
endmodule

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// Testbench for the automaton-constrained edit distance core
// Loads pattern automata, streams target bases and finish transactions, and
// checks every returned cost against an in-bench predictor of the cost vector.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import aced_pkg::*;

	localparam int NSTATES   = 1024;
	localparam int NSYMS     = 4;
	localparam int HOLD_LEN  = 40000;
	localparam int TAIL_CYC  = 3000;
	localparam int WDOG_MAX  = 200000;

	typedef struct {
		mode_t      mode;
		logic [9:0] state_index;
		logic [1:0] symbol;
		logic [9:0] next_state;
		logic       forbidden;
		bit         wait_drain;
	} aced_item_t;

	typedef struct {
		cost_t min_cost;
		logic  impossible;
	} aced_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [9:0] state_index, [11:10] symbol, [21:12] next_state, [22] forbidden
	logic [1:0]  s_tuser;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [10:0] min_cost, [11] impossible

	automaton_constrained_edit_dp_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Pending stimulus and the costs still owed by the block
	aced_item_t   pending_items[$];
	aced_result_t owed_costs[$];

	// Shadow of the block: automaton, cost vector and states in use
	logic [9:0] shadow_trans [NSTATES*NSYMS];
	logic       shadow_flag  [NSTATES];
	cost_t      shadow_cost  [NSTATES];
	int         shadow_in_use;

	int  n_accepted, n_results, n_bases, n_finishes, n_errors;
	bit  stim_done;
	bit  hold_done;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------
	function automatic void clear_costs();
		for (int j = 0; j < NSTATES; j++)
			shadow_cost[j] = COST_INF;
		shadow_cost[0] = '0;
	endfunction

	function automatic void raise_states(int s);
		int n;
		n = (s + 1 > NSTATES) ? NSTATES : s + 1;
		if (n > shadow_in_use)
			shadow_in_use = n;
	endfunction

	function automatic void relax_costs(logic [1:0] base);
		cost_t nxt [NSTATES];
		int    c, nc, t;
		for (int j = 0; j < NSTATES; j++)
			nxt[j] = COST_INF;
		for (int j = 0; j < shadow_in_use; j++) begin
			c = shadow_cost[j];
			if (c >= COST_INF)
				continue;
			for (int k = 0; k < NSYMS; k++) begin
				t = shadow_trans[j*NSYMS + k];
				if (shadow_flag[t])
					continue;
				nc = c + ((k != base) ? 1 : 0);
				if (nc > COST_INF)
					nc = COST_INF;
				if (nc < nxt[t])
					nxt[t] = cost_t'(nc);
			end
		end
		shadow_cost = nxt;
	endfunction

	// Advance the shadow by one accepted transaction; owe a cost on finish
	function automatic void track_transaction(aced_item_t it);
		aced_result_t r;
		cost_t best;
		case (it.mode)
			MODE_LOAD_TRANS: begin
				shadow_trans[it.state_index*NSYMS + it.symbol] = it.next_state;
				raise_states(it.state_index);
				raise_states(it.next_state);
			end
			MODE_LOAD_FLAG: begin
				shadow_flag[it.state_index] = it.forbidden;
				raise_states(it.state_index);
			end
			MODE_BASE: begin
				relax_costs(it.symbol);
				n_bases++;
			end
			default: begin
				best = COST_INF;
				for (int j = 0; j < NSTATES; j++)
					if (shadow_cost[j] < best)
						best = shadow_cost[j];
				r.min_cost   = best;
				r.impossible = (best >= COST_INF);
				owed_costs.insert(owed_costs.size(), r);
				clear_costs();
				n_finishes++;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------------
	function automatic void push_item(mode_t m, int si, int sym, int ns, bit fb,
					  bit drain = 1'b0);
		aced_item_t it;
		it.mode        = m;
		it.state_index = 10'(si);
		it.symbol      = 2'(sym);
		it.next_state  = 10'(ns);
		it.forbidden   = fb;
		it.wait_drain  = drain;
		pending_items.insert(pending_items.size(), it);
	endfunction

	// Load a complete automaton on states 0..n-1, targets kept below n
	function automatic void load_automaton(int n, int forbid_pct);
		for (int s = 0; s < n; s++)
			for (int k = 0; k < NSYMS; k++)
				push_item(MODE_LOAD_TRANS, s, k, $urandom_range(0, n - 1), 1'b0);
		for (int s = 0; s < n; s++)
			push_item(MODE_LOAD_FLAG, s, 0, 0,
				  (s != 0) && ($urandom_range(0, 99) < forbid_pct));
	endfunction

	function automatic void send_string(int len);
		for (int i = 0; i < len; i++)
			push_item(MODE_BASE, 0, $urandom_range(0, 3), 0, 1'b0);
		push_item(MODE_FINISH, 0, 0, 0, 1'b0);
	endfunction

	// ---------------------------------------------------------------------
	// Driver: bursts of transactions separated by random gaps
	// ---------------------------------------------------------------------
	int burst_left, gap_left;

	always @(posedge clk or negedge arst_n) begin
		aced_item_t it;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= '0;
			s_tuser    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				it.mode        = mode_t'(s_tuser);
				it.state_index = s_tdata[9:0];
				it.symbol      = s_tdata[11:10];
				it.next_state  = s_tdata[21:12];
				it.forbidden   = s_tdata[22];
				track_transaction(it);
				n_accepted++;
			end
			if (s_tvalid && !s_tready) begin
				// hold the offered transaction
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0 &&
				     (!pending_items[0].wait_drain || owed_costs.size() == 0)) begin
				it = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= it.mode;
				s_tdata  <= {1'b0, it.forbidden, it.next_state, it.symbol, it.state_index};
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: own stall pattern, one long hold-off, field-wise compare
	// ---------------------------------------------------------------------
	int stall_phase, hold_left;

	always @(posedge clk or negedge arst_n) begin
		aced_result_t want;
		if (!arst_n) begin
			m_tready    <= 1'b0;
			stall_phase <= 0;
			hold_left   <= 0;
			hold_done   <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (owed_costs.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: unexpected result cost=%0d impossible=%0b",
							 m_tdata[10:0], m_tdata[11]);
				end else begin
					want = owed_costs.pop_front();
					if (m_tdata[10:0] !== want.min_cost ||
					    m_tdata[11] !== want.impossible) begin
						n_errors++;
						if (n_errors <= 10)
							$display("ERROR: result %0d: expected cost=%0d imp=%0b, got cost=%0d imp=%0b",
								 n_results, want.min_cost, want.impossible,
								 m_tdata[10:0], m_tdata[11]);
					end
				end
			end
			// hold off once, mid-run, while the sender keeps offering
			if (!hold_done && n_accepted >= 150) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_LEN;
				m_tready  <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else begin
				stall_phase <= (stall_phase + 1) % 64;
				if (stall_phase < 24)
					m_tready <= 1'b1;
				else
					m_tready <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Watchdog: cycles without any handshake
	// ---------------------------------------------------------------------
	int idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("timeout after %0d idle cycles", WDOG_MAX);
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus plan and end of run
	// ---------------------------------------------------------------------
	initial begin
		int n, guard;
		arst_n = 1'b0;
		stim_done = 1'b0;
		n_accepted = 0; n_results = 0; n_bases = 0; n_finishes = 0; n_errors = 0;
		shadow_in_use = 0;
		for (int i = 0; i < NSTATES*NSYMS; i++)
			shadow_trans[i] = '0;
		for (int i = 0; i < NSTATES; i++)
			shadow_flag[i] = 1'b0;
		clear_costs();

		// Directed: empty automaton, finish alone -> 0, after a base -> impossible
		push_item(MODE_FINISH, 0, 0, 0, 1'b0);
		push_item(MODE_BASE, 0, 3, 0, 1'b0);
		push_item(MODE_FINISH, 0, 0, 0, 1'b0);
		// Two-state automaton: 0 -A-> 1, others back to 0, nothing forbidden
		push_item(MODE_LOAD_TRANS, 0, 0, 1, 1'b0);
		push_item(MODE_LOAD_TRANS, 0, 1, 0, 1'b0);
		push_item(MODE_LOAD_TRANS, 0, 2, 0, 1'b0);
		push_item(MODE_LOAD_TRANS, 0, 3, 0, 1'b0);
		for (int k = 0; k < NSYMS; k++)
			push_item(MODE_LOAD_TRANS, 1, k, 0, 1'b0);
		push_item(MODE_LOAD_FLAG, 0, 0, 0, 1'b0);
		push_item(MODE_LOAD_FLAG, 1, 0, 0, 1'b0);
		send_string(3);
		// Forbid state 1: every A must be substituted
		push_item(MODE_LOAD_FLAG, 1, 0, 0, 1'b1);
		push_item(MODE_BASE, 0, 0, 0, 1'b0);
		push_item(MODE_BASE, 0, 0, 0, 1'b0);
		push_item(MODE_FINISH, 0, 0, 0, 1'b0);
		// Forbid both states: no valid string
		push_item(MODE_LOAD_FLAG, 0, 0, 0, 1'b1);
		push_item(MODE_BASE, 0, 2, 0, 1'b0);
		push_item(MODE_FINISH, 0, 0, 0, 1'b0, 1'b1);
		push_item(MODE_LOAD_FLAG, 0, 0, 0, 1'b0);
		push_item(MODE_LOAD_FLAG, 1, 0, 0, 1'b0);

		// Random: small automata with random content, strings, stray reloads
		while (pending_items.size() < 560) begin
			n = $urandom_range(2, 14);
			load_automaton(n, $urandom_range(0, 60));
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 3) == 0)
					push_item(MODE_LOAD_TRANS, $urandom_range(0, n - 1),
						  $urandom_range(0, 3), $urandom_range(0, n - 1), 1'b0);
				if ($urandom_range(0, 4) == 0)
					push_item(MODE_LOAD_FLAG, $urandom_range(1, n - 1), 0, 0,
						  $urandom_range(0, 1));
				send_string($urandom_range(0, 12));
			end
		end
		// pause the sender until every cost is back
		push_item(MODE_BASE, 0, 1, 0, 1'b0, 1'b1);
		push_item(MODE_FINISH, 0, 0, 0, 1'b0);

		// Sparse automaton at the top of the state range: all states in use,
		// only states 0, 682 and 1023 reachable
		push_item(MODE_LOAD_FLAG, 0, 0, 0, 1'b0, 1'b1);
		push_item(MODE_LOAD_TRANS, 0, 0, NSTATES - 1, 1'b0);
		push_item(MODE_LOAD_TRANS, 0, 1, 682, 1'b0);
		push_item(MODE_LOAD_TRANS, 0, 2, 0, 1'b0);
		push_item(MODE_LOAD_TRANS, 0, 3, 0, 1'b0);
		for (int k = 0; k < NSYMS; k++)
			push_item(MODE_LOAD_TRANS, NSTATES - 1, k, 0, 1'b0);
		for (int k = 0; k < NSYMS; k++)
			push_item(MODE_LOAD_TRANS, 682, k, (k == 2) ? NSTATES - 1 : 0, 1'b0);
		push_item(MODE_LOAD_FLAG, 682, 0, 0, 1'b0);
		push_item(MODE_LOAD_FLAG, NSTATES - 1, 0, 0, 1'b0);
		send_string(2);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_items.size() == 0);
		@(posedge clk);
		wait (!s_tvalid && owed_costs.size() == 0);
		stim_done = 1'b1;
		guard = 0;
		while (guard < TAIL_CYC) begin
			@(posedge clk);
			guard++;
		end

		$display("run: %0d transactions in, %0d bases relaxed, %0d finishes, %0d results out",
			 n_accepted, n_bases, n_finishes, n_results);
		$display("run: automata up to %0d states, %0d mismatches", shadow_in_use, n_errors);
		if (n_errors == 0 && owed_costs.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
